[rtl/pal_pkg.sv]
// ----------------------------------------------------------------------------
// pal_pkg
// shared types, sizes and codes for the positional array list
// ----------------------------------------------------------------------------
package pal_pkg;

    localparam int CAPACITY = 32;                       // number of slots (2..64)
    localparam int IDX_W    = $clog2(CAPACITY);         // slot index width
    localparam int CNT_W    = $clog2(CAPACITY + 1);     // entry count width
    localparam int POS_W    = 6;                        // position / item_index port width
    localparam int COUNT_W  = 7;                        // count port width
    localparam int DATA_W   = 32;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef enum logic [2:0] {
        REQ_APPEND     = 3'd0,
        REQ_INSERT_AT  = 3'd1,
        REQ_REMOVE_END = 3'd2,
        REQ_REMOVE_AT  = 3'd3,
        REQ_SET        = 3'd4,
        REQ_DUMP       = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_BADPOS = 2'd2,
        STAT_EMPTY  = 2'd3
    } status_t;

    // per-cycle command broadcast along the cell row
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_WRITE  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [IDX_W-1:0] pos;
        data_t            value;
    } cell_cmd_t;

endpackage

[rtl/pal_cell.sv]
// ----------------------------------------------------------------------------
// pal_cell
// one slot of the list; shifts with its neighbors on insert and delete
// ----------------------------------------------------------------------------
module pal_cell (
    input  logic                      aclk,
    input  logic [pal_pkg::IDX_W-1:0] cell_idx,
    input  pal_pkg::cell_cmd_t        cmd,
    input  pal_pkg::data_t            left_q,
    input  pal_pkg::data_t            right_q,
    output pal_pkg::data_t            data_q
);
    import pal_pkg::*;

    data_t data_reg;
    data_t data_next;

    always_comb begin
        data_next = data_reg;
        unique case (cmd.op)
            CELL_INSERT: begin
                // target slot takes the new value, slots past it take the left neighbor
                if (cell_idx == cmd.pos) begin
                    data_next = cmd.value;
                end else if (cell_idx > cmd.pos) begin
                    data_next = left_q;
                end
            end
            CELL_DELETE: begin
                if (cell_idx >= cmd.pos) begin
                    data_next = right_q;
                end
            end
            CELL_WRITE: begin
                if (cell_idx == cmd.pos) begin
                    data_next = cmd.value;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_q = data_reg;

endmodule

[rtl/positional_array_list.sv]
// ----------------------------------------------------------------------------
// positional_array_list
// ordered list of signed 32-bit values held in a row of shifting slot cells
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY slot cells; an insert or a remove moves
// every later entry one cell right or left in the same clock, so append,
// insert at, remove last, remove at and set each produce one result
// transfer. A dump produces one result per entry (one for an empty list),
// read from the row through a single slot-select mux into the output
// register at one entry per cycle while the result channel is not stalled,
// so a dump occupies the block for the request transfer and then one load
// per entry, and input transfers are held off until its last result has
// been loaded. The output register decouples the two channels:
// a new request is taken in the cycle its predecessor's result is taken.
// Every result carries the entry count after the request and a status
// (ok, full, bad position, empty); a refused request leaves the list as is.
// Slot contents are not reset; only the entry count and control state are.
// ----------------------------------------------------------------------------
module positional_array_list (
    input  logic                        aclk,
    input  logic                        aresetn,
    // request channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [2:0]                  s_req_type,
    input  logic [pal_pkg::POS_W-1:0]   s_position,
    input  logic signed [31:0]          s_value,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [pal_pkg::COUNT_W-1:0] m_count,
    output logic                        m_has_item,
    output logic [pal_pkg::POS_W-1:0]   m_item_index,
    output logic signed [31:0]          m_item_value,
    output logic                        m_last
);
    import pal_pkg::*;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'b01,
        FSM_DUMP = 2'b10
    } fsm_t;

    fsm_t               state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   dump_idx_reg, dump_idx_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [1:0]         m_status_reg, m_status_next;
    logic [COUNT_W-1:0] m_count_reg, m_count_next;
    logic               m_has_item_reg, m_has_item_next;
    logic [POS_W-1:0]   m_item_index_reg, m_item_index_next;
    data_t              m_item_value_reg, m_item_value_next;
    logic               m_last_reg, m_last_next;

    cell_cmd_t          cmd;
    data_t              slot_q [CAPACITY];

    logic               out_free;     // output register empty or being drained
    logic               s_fire;
    logic               full;
    logic               empty;
    logic [COUNT_W-1:0] pos_ext;
    logic [COUNT_W-1:0] cnt_ext;
    logic               dump_last;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == FSM_IDLE) && out_free;
    assign s_fire    = s_valid && s_ready;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign pos_ext   = COUNT_W'(s_position);
    assign cnt_ext   = COUNT_W'(count_reg);
    assign dump_last = (dump_idx_reg == IDX_W'(count_reg - CNT_W'(1)));

    // row of slot cells, each handing its value to both neighbors
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        data_t left_d;
        data_t right_d;

        if (i == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = slot_q[i-1];
        end

        if (i == CAPACITY - 1) begin : g_final
            assign right_d = '0;
        end else begin : g_mid_r
            assign right_d = slot_q[i+1];
        end

        pal_cell u_cell (
            .aclk     (aclk),
            .cell_idx (IDX_W'(i)),
            .cmd      (cmd),
            .left_q   (left_d),
            .right_q  (right_d),
            .data_q   (slot_q[i])
        );
    end

    // request decode, list update and result loading
    always_comb begin
        state_next        = state_reg;
        count_next        = count_reg;
        dump_idx_next     = dump_idx_reg;
        cmd.op            = CELL_HOLD;
        cmd.pos           = IDX_W'(s_position);
        cmd.value         = s_value;

        m_valid_next      = m_valid_reg && !m_ready;
        m_status_next     = m_status_reg;
        m_count_next      = m_count_reg;
        m_has_item_next   = m_has_item_reg;
        m_item_index_next = m_item_index_reg;
        m_item_value_next = m_item_value_reg;
        m_last_next       = m_last_reg;

        unique case (state_reg)
            FSM_IDLE: begin
                if (s_fire) begin
                    // single result unless a non-empty dump
                    m_valid_next      = 1'b1;
                    m_status_next     = STAT_OK;
                    m_has_item_next   = 1'b0;
                    m_item_index_next = '0;
                    m_item_value_next = '0;
                    m_last_next       = 1'b1;

                    priority case (s_req_type)
                        REQ_APPEND: begin
                            if (full) begin
                                m_status_next = STAT_FULL;
                            end else begin
                                cmd.op     = CELL_INSERT;
                                cmd.pos    = IDX_W'(count_reg);
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_INSERT_AT: begin
                            if (full) begin
                                m_status_next = STAT_FULL;
                            end else if (pos_ext > cnt_ext) begin
                                m_status_next = STAT_BADPOS;
                            end else begin
                                cmd.op     = CELL_INSERT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_REMOVE_END: begin
                            if (empty) begin
                                m_status_next = STAT_EMPTY;
                            end else begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        REQ_REMOVE_AT: begin
                            if (empty) begin
                                m_status_next = STAT_EMPTY;
                            end else if (pos_ext >= cnt_ext) begin
                                m_status_next = STAT_BADPOS;
                            end else begin
                                cmd.op     = CELL_DELETE;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        REQ_SET: begin
                            if (pos_ext >= cnt_ext) begin
                                m_status_next = STAT_BADPOS;
                            end else begin
                                cmd.op = CELL_WRITE;
                            end
                        end
                        REQ_DUMP: begin
                            // stream entries from slot 0; empty list gives the default result
                            if (!empty) begin
                                m_valid_next  = 1'b0;
                                dump_idx_next = '0;
                                state_next    = FSM_DUMP;
                            end
                        end
                        default: begin
                            // unknown request: list untouched, plain ok result
                        end
                    endcase

                    m_count_next = COUNT_W'(count_next);
                end
            end
            FSM_DUMP: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_status_next     = STAT_OK;
                    m_count_next      = cnt_ext;
                    m_has_item_next   = 1'b1;
                    m_item_index_next = POS_W'(dump_idx_reg);
                    m_item_value_next = slot_q[dump_idx_reg];
                    m_last_next       = dump_last;
                    dump_idx_next     = dump_idx_reg + IDX_W'(1);
                    if (dump_last) begin
                        state_next = FSM_IDLE;
                    end
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FSM_IDLE;
            count_reg    <= '0;
            dump_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            dump_idx_reg <= dump_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        m_status_reg     <= m_status_next;
        m_count_reg      <= m_count_next;
        m_has_item_reg   <= m_has_item_next;
        m_item_index_reg <= m_item_index_next;
        m_item_value_reg <= m_item_value_next;
        m_last_reg       <= m_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_count      = m_count_reg;
    assign m_has_item   = m_has_item_reg;
    assign m_item_index = m_item_index_reg;
    assign m_item_value = m_item_value_reg;
    assign m_last       = m_last_reg;

    // entry count never exceeds the slot row
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // no request transfer while a dump is streaming
    a_dump_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FSM_DUMP) |-> !s_ready)
        else $error("request taken during dump");

    // every accepted request that is not a dump of a non-empty list yields a result
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !(s_req_type == REQ_DUMP && !empty)) |=> m_valid_reg)
        else $error("request produced no result");

    // the final dumped entry is the entry at count minus one
    a_dump_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_has_item_reg && m_last_reg)
            |-> (COUNT_W'(m_item_index_reg) + COUNT_W'(1) == m_count_reg))
        else $error("dump ended at wrong slot");

endmodule

[test/positional_array_list_tb.sv]
// ----------------------------------------------------------------------------
// positional_array_list_tb
// self-checking testbench for the positional array list
// ----------------------------------------------------------------------------
// A queue of requests is built up front: a short directed list that covers the
// corner cases, then random traffic that alternates between growing the list
// up to capacity and draining it to empty. Mixed in are sets, dumps and some
// out-of-range or unused request codes. A clocked driver sends the queue in
// bursts with random gaps. A clocked monitor takes results under a rotating
// back-pressure pattern. Every accepted request runs through a behavioral
// list model that queues the results it should cause, and each result
// transfer is checked against the oldest one.
// ----------------------------------------------------------------------------
module positional_array_list_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pal_pkg::*;

    // request codes the block does not define; they must leave the list alone
    localparam logic [2:0] REQ_SPARE_6 = 3'd6;
    localparam logic [2:0] REQ_SPARE_7 = 3'd7;

    localparam int N_RANDOM   = 360;
    localparam int MAX_REPORT = 10;

    typedef struct {
        logic [2:0]       kind;
        logic [POS_W-1:0] pos;
        data_t            value;
    } request_t;

    typedef struct packed {
        status_t            status;
        logic [COUNT_W-1:0] count;
        logic               has_item;
        logic [POS_W-1:0]   index;
        data_t              value;
        logic               last;
    } result_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #5ns aclk = ~aclk;

    // dut ports, all inputs known from time zero
    logic               s_valid    = 1'b0;
    logic               s_ready;
    logic [2:0]         s_req_type = REQ_APPEND;
    logic [POS_W-1:0]   s_position = '0;
    logic signed [31:0] s_value    = '0;
    logic               m_valid;
    logic               m_ready    = 1'b0;
    logic [1:0]         m_status;
    logic [COUNT_W-1:0] m_count;
    logic               m_has_item;
    logic [POS_W-1:0]   m_item_index;
    logic signed [31:0] m_item_value;
    logic               m_last;

    positional_array_list dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_position   (s_position),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_count      (m_count),
        .m_has_item   (m_has_item),
        .m_item_index (m_item_index),
        .m_item_value (m_item_value),
        .m_last       (m_last)
    );

    // ------------------------------------------------------------------------
    // list model: its own copy of the slots and the entry count
    // ------------------------------------------------------------------------
    data_t   list_slots [CAPACITY];
    int      list_len = 0;
    result_t expected_results [$];

    // bookkeeping for the closing summary
    int op_tally [8];
    int status_tally [4];
    int results_checked = 0;
    int entries_dumped  = 0;
    int errors          = 0;

    function automatic void push_result(status_t st, logic has, int idx, data_t v,
                                        logic lst);
        result_t r;
        r.status   = st;
        r.count    = COUNT_W'(list_len);
        r.has_item = has;
        r.index    = POS_W'(idx);
        r.value    = v;
        r.last     = lst;
        expected_results.push_back(r);
    endfunction

    // apply one accepted request and queue the results it should produce
    function automatic void list_apply(request_t rq);
        status_t st;
        int      i;
        st = STAT_OK;
        op_tally[rq.kind]++;
        case (rq.kind)
            REQ_APPEND: begin
                if (list_len >= CAPACITY) begin
                    st = STAT_FULL;
                end else begin
                    list_slots[list_len] = rq.value;
                    list_len++;
                end
            end
            REQ_INSERT_AT: begin
                if (list_len >= CAPACITY) begin
                    st = STAT_FULL;
                end else if (rq.pos > list_len) begin
                    st = STAT_BADPOS;
                end else begin
                    // everything at and after pos moves one slot right
                    for (i = list_len; i > rq.pos; i--)
                        list_slots[i] = list_slots[i-1];
                    list_slots[rq.pos] = rq.value;
                    list_len++;
                end
            end
            REQ_REMOVE_END: begin
                if (list_len == 0)
                    st = STAT_EMPTY;
                else
                    list_len--;
            end
            REQ_REMOVE_AT: begin
                if (list_len == 0) begin
                    st = STAT_EMPTY;
                end else if (rq.pos >= list_len) begin
                    st = STAT_BADPOS;
                end else begin
                    // later entries close the gap
                    for (i = rq.pos; i + 1 < list_len; i++)
                        list_slots[i] = list_slots[i+1];
                    list_len--;
                end
            end
            REQ_SET: begin
                // an empty list has no valid position either
                if (rq.pos >= list_len)
                    st = STAT_BADPOS;
                else
                    list_slots[rq.pos] = rq.value;
            end
            REQ_DUMP: begin
                if (list_len == 0) begin
                    push_result(STAT_OK, 1'b0, 0, '0, 1'b1);
                end else begin
                    for (i = 0; i < list_len; i++)
                        push_result(STAT_OK, 1'b1, i, list_slots[i], i + 1 == list_len);
                    entries_dumped += list_len;
                end
                status_tally[STAT_OK]++;
                return;
            end
            default: ;  // unused codes: list untouched, plain ok result
        endcase
        status_tally[st]++;
        push_result(st, 1'b0, 0, '0, 1'b1);
    endfunction

    // ------------------------------------------------------------------------
    // stimulus planning
    // ------------------------------------------------------------------------
    request_t pending_requests [$];
    int       plan_len      = 0;  // entry count as the plan will leave it
    int       planned_total = 0;
    int       accepted_total = 0;

    // queue a request and track the count it leads to, so later positions
    // can be aimed inside the list
    task automatic queue_request(logic [2:0] kind, int pos, data_t value);
        request_t rq;
        rq.kind  = kind;
        rq.pos   = POS_W'(pos);
        rq.value = value;
        pending_requests.push_back(rq);
        case (kind)
            REQ_APPEND:     if (plan_len < CAPACITY) plan_len++;
            REQ_INSERT_AT:  if (plan_len < CAPACITY && rq.pos <= plan_len) plan_len++;
            REQ_REMOVE_END: if (plan_len > 0) plan_len--;
            REQ_REMOVE_AT:  if (rq.pos < plan_len) plan_len--;
            default: ;
        endcase
    endtask

    // random value with the two extremes and the zero/minus-one patterns mixed in
    function automatic data_t pick_value();
        case ($urandom_range(11))
            0:       return data_t'(32'h8000_0000);
            1:       return data_t'(32'h7fff_ffff);
            2:       return data_t'(32'hffff_ffff);
            3:       return '0;
            default: return data_t'($urandom);
        endcase
    endfunction

    // one edit that grows or shrinks the list; now and then aimed off the end
    task automatic queue_edit(bit grow);
        int p;
        if (grow) begin
            p = ($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(plan_len);
            if ($urandom_range(1))
                queue_request(REQ_APPEND, $urandom_range(63), pick_value());
            else
                queue_request(REQ_INSERT_AT, p, pick_value());
        end else begin
            p = ($urandom_range(7) == 0 || plan_len == 0) ? $urandom_range(63)
                                                           : $urandom_range(plan_len - 1);
            if ($urandom_range(1))
                queue_request(REQ_REMOVE_END, $urandom_range(63), pick_value());
            else
                queue_request(REQ_REMOVE_AT, p, pick_value());
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: bursts of random length separated by random gaps
    // ------------------------------------------------------------------------
    request_t drive_rq;
    int       burst_left = 0;
    int       gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            // the payload on the ports is the one moved by this transfer
            if (s_valid && s_ready) begin
                list_apply('{s_req_type, s_position, s_value});
                accepted_total++;
            end
            // payload may only change once the current one is gone
            if (!s_valid || s_ready) begin
                if (gap_left > 0 || pending_requests.size() == 0) begin
                    if (gap_left > 0)
                        gap_left--;
                    s_valid <= 1'b0;
                end else begin
                    drive_rq = pending_requests.pop_front();
                    s_valid    <= 1'b1;
                    s_req_type <= drive_rq.kind;
                    s_position <= drive_rq.pos;
                    s_value    <= drive_rq.value;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        // mostly short bursts, sometimes long unbroken runs
                        burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 90)
                                                              : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver back-pressure: a rotating 13-bit pattern, redrawn now and then;
    // some stretches have no stall at all
    // ------------------------------------------------------------------------
    logic [12:0] stall_pattern = 13'h1;
    int          pattern_age   = 0;
    logic        no_stall      = 1'b1;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (pattern_age == 0) begin
                pattern_age   = $urandom_range(50, 300);
                no_stall      = ($urandom_range(3) == 0);
                stall_pattern = 13'($urandom) | 13'h1;  // at least one ready slot
            end
            pattern_age--;
            stall_pattern = {stall_pattern[0], stall_pattern[12:1]};
            m_ready <= no_stall | stall_pattern[0];
        end
    end

    // ------------------------------------------------------------------------
    // monitor: check each result transfer against the oldest expectation
    // ------------------------------------------------------------------------
    result_t got_result;
    result_t want_result;

    function automatic string fmt_result(result_t r);
        return $sformatf("status=%0d count=%0d has_item=%0b index=%0d value=%0d last=%0b",
                         r.status, r.count, r.has_item, r.index, r.value, r.last);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_result = '{status_t'(m_status), m_count, m_has_item, m_item_index,
                           m_item_value, m_last};
            results_checked++;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORT)
                    $display("ERROR: result with nothing expected: %s",
                             fmt_result(got_result));
            end else begin
                want_result = expected_results.pop_front();
                if (got_result !== want_result) begin
                    errors++;
                    if (errors <= MAX_REPORT) begin
                        $display("ERROR: result %0d mismatch", results_checked);
                        $display("  expected %s", fmt_result(want_result));
                        $display("  actual   %s", fmt_result(got_result));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int  n;
        bit  growing;
        bit  at_limit;
        int  roll;

        // directed: empty-list cases first
        queue_request(REQ_DUMP,       0,  '0);                        // dump of empty list
        queue_request(REQ_REMOVE_END, 0,  '0);                        // remove on empty
        queue_request(REQ_REMOVE_AT,  0,  '0);                        // remove at on empty
        queue_request(REQ_SET,        0,  data_t'(32'h1234_5678));    // set on empty
        queue_request(REQ_INSERT_AT,  1,  data_t'(32'h0000_0001));    // insert past count
        // build a list with the value extremes
        queue_request(REQ_INSERT_AT,  0,  data_t'(32'h7fff_ffff));
        queue_request(REQ_APPEND,     63, data_t'(32'h8000_0000));
        queue_request(REQ_APPEND,     0,  data_t'(32'hffff_ffff));
        queue_request(REQ_APPEND,     0,  '0);
        queue_request(REQ_INSERT_AT,  4,  data_t'(32'h5555_5555));    // insert at count
        queue_request(REQ_INSERT_AT,  2,  data_t'(32'haaaa_aaaa));    // insert in middle
        queue_request(REQ_INSERT_AT,  63, data_t'(32'h0f0f_0f0f));    // position far out
        queue_request(REQ_SET,        5,  data_t'(32'h1234_5678));    // last entry
        queue_request(REQ_SET,        6,  data_t'(32'h2222_2222));    // set at count
        queue_request(REQ_SET,        63, data_t'(32'h3333_3333));
        queue_request(REQ_REMOVE_AT,  63, '0);
        queue_request(REQ_DUMP,       0,  '0);
        queue_request(REQ_REMOVE_AT,  0,  '0);                        // shift whole list
        queue_request(REQ_REMOVE_END, 0,  '0);
        queue_request(REQ_SPARE_6,    63, data_t'(32'hffff_ffff));
        queue_request(REQ_SPARE_7,    42, data_t'(32'h8000_0000));
        queue_request(REQ_REMOVE_AT,  3,  '0);                        // remove the last one
        queue_request(REQ_DUMP,       63, data_t'(32'hffff_ffff));

        // random: swing between filling to capacity and draining to empty,
        // with sets, dumps and junk requests sprinkled in
        growing = 1'b1;
        for (n = 0; n < N_RANDOM; n++) begin
            at_limit = growing ? (plan_len == CAPACITY) : (plan_len == 0);
            if (at_limit) begin
                // one refused edit at the limit, then maybe turn around
                queue_edit(growing);
                if ($urandom_range(1))
                    growing = !growing;
            end else begin
                roll = $urandom_range(99);
                if (roll < 6)
                    queue_request(3'($urandom_range(7)), $urandom_range(63), pick_value());
                else if (roll < 12)
                    queue_request(REQ_DUMP, $urandom_range(63), pick_value());
                else if (roll < 22)
                    queue_request(REQ_SET,
                                  ($urandom_range(7) == 0 || plan_len == 0)
                                      ? $urandom_range(63) : $urandom_range(plan_len - 1),
                                  pick_value());
                else
                    queue_edit(($urandom_range(3) != 0) == growing);
            end
        end
        queue_request(REQ_DUMP, 0, '0);
        planned_total = pending_requests.size();

        // synchronous reset, released at a rising edge
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // every request accepted and every expected result seen
        while (accepted_total < planned_total || expected_results.size() != 0)
            @(posedge aclk);
        // then leave room for any stray transfer
        repeat (4 * CAPACITY) @(posedge aclk);

        $display("run: %0d requests (append %0d, insert %0d, remove last %0d, remove at %0d,",
                 accepted_total, op_tally[REQ_APPEND], op_tally[REQ_INSERT_AT],
                 op_tally[REQ_REMOVE_END], op_tally[REQ_REMOVE_AT]);
        $display({"  set %0d, dump %0d, unused %0d); %0d results, %0d entries dumped,",
                  " full %0d, bad position %0d, empty %0d"},
                 op_tally[REQ_SET], op_tally[REQ_DUMP],
                 op_tally[REQ_SPARE_6] + op_tally[REQ_SPARE_7], results_checked,
                 entries_dumped, status_tally[STAT_FULL], status_tally[STAT_BADPOS],
                 status_tally[STAT_EMPTY]);
        if (errors > MAX_REPORT)
            $display("%0d mismatches in total", errors);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog: far beyond the slowest legal run (every request a full dump,
    // every result under the longest stall)
    initial begin
        #20ms;
        $display("timeout: %0d of %0d requests accepted, %0d results outstanding",
                 accepted_total, planned_total, expected_results.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
